/* design/tsac_pkg.sv */
// Shared types and constants for the triggered serial converter capture block.
// Used by tsac_core, tsac_out_buf and triggered_serial_adc_capture.
package tsac_pkg;

    localparam int FRAME_BITS_DEFAULT = 32;
    localparam int SAMPLE_W           = 24;
    localparam int TIME_W             = 32;
    localparam int COUNT_W            = 16;
    localparam int BITCNT_W           = 6;

    localparam logic [COUNT_W-1:0]  SAMPLE_COUNT_RESET = 16'd1600;
    localparam logic [BITCNT_W-1:0] BITCNT_MAX         = 6'd63;
    localparam logic [BITCNT_W-1:0] FIELD_FIRST        = 6'd8;

    // Register index, taken from paddr[2]
    localparam logic REG_SAMPLE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        OP_ARM     = 2'd0,
        OP_TRIGGER = 2'd1,
        OP_DRDY    = 2'd2,
        OP_BCLK    = 2'd3
    } op_t;

    typedef struct packed {
        logic [TIME_W-1:0]   elapsed_us;
        logic [SAMPLE_W-1:0] sample0;
        logic [SAMPLE_W-1:0] sample1;
        logic [SAMPLE_W-1:0] sample2;
        logic                last;
    } res_t;

endpackage

/* design/tsac_core.sv */
// Capture state and frame assembly: arm, trigger, frame start and bit sampling.
// Depends on tsac_pkg; produces at most one result word per accepted input word.
module tsac_core #(
    parameter int FRAME_BITS = tsac_pkg::FRAME_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_fire,
    input  logic [1:0]                      in_op,
    input  logic                            in_line0,
    input  logic                            in_line1,
    input  logic                            in_line2,
    input  logic [tsac_pkg::TIME_W-1:0]     in_now_us,
    input  logic [tsac_pkg::COUNT_W-1:0]    sample_count,
    output logic                            res_valid,
    output tsac_pkg::res_t                  res_data
);
    import tsac_pkg::*;

    localparam logic [BITCNT_W-1:0] FB_END   = BITCNT_W'(FRAME_BITS);
    localparam logic [BITCNT_W-1:0] FB_EMIT  = BITCNT_W'(FRAME_BITS + 1);

    logic                    armed_reg, armed_next;
    logic                    trig_reg, trig_next;
    logic [BITCNT_W-1:0]     bitcnt_reg, bitcnt_next;
    logic [SAMPLE_W-1:0]     frame_reg [3];
    logic [SAMPLE_W-1:0]     frame_next [3];
    logic [TIME_W-1:0]       start_reg, start_next;
    logic [COUNT_W-1:0]      captured_reg, captured_next;

    logic [2:0]              lines;
    logic [4:0]              bit_pos;
    logic [COUNT_W:0]        captured_inc;
    logic                    fin;

    assign lines        = {in_line2, in_line1, in_line0};
    // Frame position p carries weight 2^(31-p); 31-p is the inverse of p's low bits.
    assign bit_pos      = ~bitcnt_reg[4:0];
    assign captured_inc = {1'b0, captured_reg} + {{COUNT_W{1'b0}}, 1'b1};
    assign fin          = captured_inc >= {1'b0, sample_count};

    always_comb begin
        armed_next    = armed_reg;
        trig_next     = trig_reg;
        bitcnt_next   = bitcnt_reg;
        start_next    = start_reg;
        captured_next = captured_reg;
        for (int c = 0; c < 3; c++) begin
            frame_next[c] = frame_reg[c];
        end
        res_valid           = 1'b0;
        res_data.elapsed_us = in_now_us - start_reg;
        res_data.sample0    = frame_reg[0];
        res_data.sample1    = frame_reg[1];
        res_data.sample2    = frame_reg[2];
        res_data.last       = fin;

        if (in_fire) begin
            case (op_t'(in_op))
                OP_ARM: begin
                    if (!armed_reg) begin
                        armed_next    = 1'b1;
                        captured_next = '0;
                    end
                end
                OP_TRIGGER: begin
                    if (armed_reg && !trig_reg) begin
                        trig_next   = 1'b1;
                        start_next  = in_now_us;
                        bitcnt_next = BITCNT_MAX;
                    end
                end
                OP_DRDY: begin
                    if (trig_reg) begin
                        bitcnt_next = '0;
                        for (int c = 0; c < 3; c++) begin
                            frame_next[c] = '0;
                        end
                    end
                end
                OP_BCLK: begin
                    if (armed_reg) begin
                        if (bitcnt_reg < FB_END) begin
                            if (!bitcnt_reg[5] && bitcnt_reg >= FIELD_FIRST) begin
                                for (int c = 0; c < 3; c++) begin
                                    frame_next[c][bit_pos] = lines[c];
                                end
                            end
                            bitcnt_next = bitcnt_reg + 1'b1;
                        end else if (bitcnt_reg == FB_EMIT) begin
                            bitcnt_next = bitcnt_reg + 1'b1;
                            if (trig_reg) begin
                                res_valid = 1'b1;
                                if (fin) begin
                                    armed_next    = 1'b0;
                                    trig_next     = 1'b0;
                                    captured_next = '0;
                                end else begin
                                    captured_next = captured_inc[COUNT_W-1:0];
                                end
                            end
                        end else if (bitcnt_reg != BITCNT_MAX) begin
                            bitcnt_next = bitcnt_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg    <= 1'b0;
            trig_reg     <= 1'b0;
            bitcnt_reg   <= '0;
            start_reg    <= '0;
            captured_reg <= '0;
            for (int c = 0; c < 3; c++) begin
                frame_reg[c] <= '0;
            end
        end else begin
            armed_reg    <= armed_next;
            trig_reg     <= trig_next;
            bitcnt_reg   <= bitcnt_next;
            start_reg    <= start_next;
            captured_reg <= captured_next;
            for (int c = 0; c < 3; c++) begin
                frame_reg[c] <= frame_next[c];
            end
        end
    end

endmodule

/* design/tsac_out_buf.sv */
// Two-entry result buffer between the capture logic and the result channel.
// Depends on tsac_pkg for the result word type.
module tsac_out_buf (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  tsac_pkg::res_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output tsac_pkg::res_t out_data
);
    import tsac_pkg::*;

    res_t       slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    logic       wr_idx;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[0];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign wr_idx    = count_reg[0] ^ pop;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // The head moves up on a pop; a push into the same slot takes precedence.
    always_ff @(posedge aclk) begin
        if (pop) begin
            slot_reg[0] <= slot_reg[1];
        end
        if (push) begin
            slot_reg[wr_idx] <= in_data;
        end
    end

endmodule

/* design/triggered_serial_adc_capture.sv */
// Top level of the triggered three-line serial converter capture block.
// Depends on tsac_pkg, tsac_core and tsac_out_buf.
//
// Usage: each input word on the s_ channel carries an event code (arm, trigger,
// data-ready rising edge or bit-clock falling edge), the levels of the three
// serial data lines and the free-running microsecond time. Arm enables capture,
// trigger records the start time, each data-ready edge opens a frame and each
// bit-clock edge samples the lines. On the bit-clock edge after the frame ends,
// one result word appears on the m_ channel: three unsigned 24-bit samples, the
// microseconds since the trigger, and a last flag on the final sample of the
// acquisition, after which the block disarms.
// An input word is taken every cycle while the buffer has space; its result
// is registered in the result buffer and offered on the m_ channel. Sustained
// rate is one word per cycle while s_ready is high, set by the capture logic.
// Reset (synchronous, active low) disarms, clears all capture state and loads
// the sample count with 1600. The sample count register is written over APB
// at byte address 0; the user must do so only while idle (not enforced).
// When the receiver stalls, a two-entry result buffer absorbs results; s_ready
// falls only once both entries are held, so words are never lost.
module triggered_serial_adc_capture #(
    parameter int FRAME_BITS = tsac_pkg::FRAME_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input word channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_op,
    input  logic                           s_line0,
    input  logic                           s_line1,
    input  logic                           s_line2,
    input  logic [tsac_pkg::TIME_W-1:0]    s_now_us,
    // Result word channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [tsac_pkg::TIME_W-1:0]    m_elapsed_us,
    output logic [tsac_pkg::SAMPLE_W-1:0]  m_sample0,
    output logic [tsac_pkg::SAMPLE_W-1:0]  m_sample1,
    output logic [tsac_pkg::SAMPLE_W-1:0]  m_sample2,
    output logic                           m_last,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import tsac_pkg::*;

    logic [COUNT_W-1:0] sample_count_reg;
    logic               in_fire;
    logic               res_valid;
    res_t               res_data;
    res_t               out_data;

    // The single register sits at byte address 0; paddr[2] selects beyond it.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SAMPLE_COUNT) ? {16'd0, sample_count_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= SAMPLE_COUNT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_SAMPLE_COUNT) begin
            sample_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign in_fire = s_valid && s_ready;

    tsac_core #(
        .FRAME_BITS(FRAME_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .in_op       (s_op),
        .in_line0    (s_line0),
        .in_line1    (s_line1),
        .in_line2    (s_line2),
        .in_now_us   (s_now_us),
        .sample_count(sample_count_reg),
        .res_valid   (res_valid),
        .res_data    (res_data)
    );

    // Results are only produced on accepted words, which requires buffer space.
    tsac_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_ready (s_ready),
        .in_data  (res_data),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data (out_data)
    );

    assign m_elapsed_us = out_data.elapsed_us;
    assign m_sample0    = out_data.sample0;
    assign m_sample1    = out_data.sample1;
    assign m_sample2    = out_data.sample2;
    assign m_last       = out_data.last;

endmodule

/* verif/capture_checker.sv */
// Checker for the triggered serial converter capture block: predicts each result word
// from the accepted input words and register writes, and compares what the block returns.
// Depends on tsac_pkg for the event codes, the result layout and the reset constants.
module capture_checker #(
    parameter int FRAME_BITS = tsac_pkg::FRAME_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic        s_line0,
    input  logic        s_line1,
    input  logic        s_line2,
    input  logic [31:0] s_now_us,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_elapsed_us,
    input  logic [23:0] m_sample0,
    input  logic [23:0] m_sample1,
    input  logic [23:0] m_sample2,
    input  logic        m_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          n_expected,
    output int          n_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    import tsac_pkg::*;

    localparam logic [2:0] SAMPLE_COUNT_ADDR = {REG_SAMPLE_COUNT, 2'b00};
    localparam int         FRAME_WORD_BITS   = 32;

    // Shadow of the capture state, kept in step with the accepted words.
    logic [15:0] acq_len;
    logic        is_armed;
    logic        is_triggered;
    logic [5:0]  bit_pos;
    logic [23:0] frame_acc [3];
    logic [31:0] t_start;
    logic [15:0] n_taken;

    res_t pending_samples [$];
    int   fault_count = 0;

    assign n_errors = fault_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] capture mismatch: %s got 0x%0h, expected 0x%0h",
                 $realtime, what, got, want);
        fault_count++;
    endtask

    // Applies one accepted word to the shadow state; queues a sample when a frame closes.
    function automatic void advance_capture(input op_t op, input logic [2:0] lvl,
                                            input logic [31:0] now_us);
        res_t        hit;
        logic [16:0] next_n;
        next_n = {1'b0, n_taken} + 17'd1;
        case (op)
            OP_ARM: begin
                if (!is_armed) begin
                    is_armed = 1'b1;
                    n_taken  = '0;
                end
            end
            OP_TRIGGER: begin
                if (is_armed && !is_triggered) begin
                    is_triggered = 1'b1;
                    t_start      = now_us;
                    bit_pos      = BITCNT_MAX;
                end
            end
            OP_DRDY: begin
                if (is_triggered) begin
                    bit_pos = '0;
                    for (int c = 0; c < 3; c++)
                        frame_acc[c] = '0;
                end
            end
            default: begin
                if (is_armed) begin
                    if (bit_pos < FRAME_BITS) begin
                        if (bit_pos >= FIELD_FIRST && bit_pos < FRAME_WORD_BITS) begin
                            for (int c = 0; c < 3; c++)
                                frame_acc[c][FRAME_WORD_BITS - 1 - bit_pos] = lvl[c];
                        end
                        bit_pos++;
                    end else if (bit_pos == FRAME_BITS + 1) begin
                        bit_pos++;
                        if (is_triggered) begin
                            hit.elapsed_us = now_us - t_start;
                            hit.sample0    = frame_acc[0];
                            hit.sample1    = frame_acc[1];
                            hit.sample2    = frame_acc[2];
                            hit.last       = (next_n >= {1'b0, acq_len});
                            pending_samples = {pending_samples, hit};
                            if (hit.last) begin
                                is_armed     = 1'b0;
                                is_triggered = 1'b0;
                                n_taken      = '0;
                            end else begin
                                n_taken = next_n[15:0];
                            end
                        end
                    end else if (bit_pos < BITCNT_MAX) begin
                        bit_pos++;
                    end
                end
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            acq_len      = SAMPLE_COUNT_RESET;
            is_armed     = 1'b0;
            is_triggered = 1'b0;
            bit_pos      = '0;
            t_start      = '0;
            n_taken      = '0;
            for (int c = 0; c < 3; c++)
                frame_acc[c] = '0;
            pending_samples.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_samples.size() == 0) begin
                    report_mismatch("result word with none expected, elapsed_us",
                                    m_elapsed_us, '0);
                end else begin
                    want = pending_samples.pop_front();
                    if (m_elapsed_us !== want.elapsed_us)
                        report_mismatch("elapsed_us", m_elapsed_us, want.elapsed_us);
                    if (m_sample0 !== want.sample0)
                        report_mismatch("sample0", 32'(m_sample0), 32'(want.sample0));
                    if (m_sample1 !== want.sample1)
                        report_mismatch("sample1", 32'(m_sample1), 32'(want.sample1));
                    if (m_sample2 !== want.sample2)
                        report_mismatch("sample2", 32'(m_sample2), 32'(want.sample2));
                    if (m_last !== want.last)
                        report_mismatch("last", 32'(m_last), 32'(want.last));
                end
            end
            if (psel && penable && pwrite && pready && paddr == SAMPLE_COUNT_ADDR)
                acq_len = pwdata[15:0];
            if (s_valid && s_ready)
                advance_capture(op_t'(s_op), {s_line2, s_line1, s_line0}, s_now_us);
        end
        n_expected <= pending_samples.size();
    end

endmodule

/* verif/testbench.sv */
// Top of the testbench for triggered_serial_adc_capture: clock, reset, input words,
// register writes over the APB port, result back-pressure and the final verdict.
// Depends on tsac_pkg, the capture block and capture_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tsac_pkg::*;

    localparam int          FRAME_BITS        = FRAME_BITS_DEFAULT;
    // A complete frame: one data-ready edge, then enough bit clocks to reach the
    // emitting edge that follows the end of the frame.
    localparam int          FULL_FRAME_CLOCKS = FRAME_BITS + 2;
    localparam logic [2:0]  SAMPLE_COUNT_ADDR = {REG_SAMPLE_COUNT, 2'b00};
    // The second register slot does not exist; writes there must change nothing.
    localparam logic [2:0]  UNUSED_REG_ADDR   = {~REG_SAMPLE_COUNT, 2'b00};
    localparam int          PHASE_WORDS       = 215;
    localparam int          MIN_RESULTS       = 48;
    localparam int          SETTLE_CYCLES     = 8;
    localparam int          LONG_HOLD_CYCLES  = 400;
    localparam int          CYCLE_LIMIT       = 400000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_op;
    logic        s_line0;
    logic        s_line1;
    logic        s_line2;
    logic [31:0] s_now_us;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_elapsed_us;
    logic [23:0] m_sample0;
    logic [23:0] m_sample1;
    logic [23:0] m_sample2;
    logic        m_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          n_expected;
    int          n_errors;
    int unsigned burst_left   = 0;
    int unsigned words_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count  = 0;
    logic [31:0] t_us;
    logic        ask_long_hold;

    always #1 aclk = ~aclk;

    triggered_serial_adc_capture #(
        .FRAME_BITS (FRAME_BITS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_line0      (s_line0),
        .s_line1      (s_line1),
        .s_line2      (s_line2),
        .s_now_us     (s_now_us),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_elapsed_us (m_elapsed_us),
        .m_sample0    (m_sample0),
        .m_sample1    (m_sample1),
        .m_sample2    (m_sample2),
        .m_last       (m_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    capture_checker #(
        .FRAME_BITS (FRAME_BITS)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_line0      (s_line0),
        .s_line1      (s_line1),
        .s_line2      (s_line2),
        .s_now_us     (s_now_us),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_elapsed_us (m_elapsed_us),
        .m_sample0    (m_sample0),
        .m_sample1    (m_sample1),
        .m_sample2    (m_sample2),
        .m_last       (m_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .n_expected   (n_expected),
        .n_errors     (n_errors)
    );

    // Results taken by the sink. The random part uses this only to decide when it
    // has seen enough complete frames; it plays no part in the verdict.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            results_seen <= results_seen + 1;
    end

    // Watchdog. A correct run finishes far inside this limit, even with every word
    // waiting out the longest sender gap and every result the longest sink stall.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Result sink. It switches between always ready, a coin toss, mostly stalled and
    // mostly ready, each for a random number of cycles. Once asked, it holds off for a
    // long stretch so that the result buffer fills and the block stalls its input.
    initial begin : result_sink
        int unsigned run_left;
        int unsigned style;
        bit          long_hold_done;
        run_left       = 0;
        style          = 0;
        long_hold_done = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (ask_long_hold && !long_hold_done) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (run_left == 0) begin
                    style    = $urandom_range(0, 3);
                    run_left = $urandom_range(16, 160);
                end
                run_left--;
                case (style)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // Free-running microsecond time: mostly small steps forward, now and then a jump
    // to anywhere, so that the elapsed time also wraps past 2^32.
    function automatic logic [31:0] next_time();
        if ($urandom_range(0, 9) == 0)
            t_us = $urandom;
        else
            t_us = t_us + $urandom_range(0, 40);
        return t_us;
    endfunction

    // Offers one word and waits until it is taken. The sender works in bursts of random
    // length; between bursts it may idle for a few cycles, or carry straight on.
    task automatic send_word(input op_t op, input logic [2:0] lvl, input logic [31:0] now);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid  <= 1'b1;
        s_op     <= op;
        s_line0  <= lvl[0];
        s_line1  <= lvl[1];
        s_line2  <= lvl[2];
        s_now_us <= now;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        words_sent++;
    endtask

    // Line levels for one bit clock. Styles: fully random, all ones, all zeros,
    // a fixed level per line for the whole frame, and alternating bits.
    function automatic logic [2:0] frame_levels(input int unsigned style,
                                                input logic [2:0] fixed, input int pos);
        case (style)
            1: return 3'b111;
            2: return 3'b000;
            3: return fixed;
            4: return {3{pos[0]}};
            default: return 3'($urandom_range(0, 7));
        endcase
    endfunction

    // One data-ready edge followed by the given number of bit clocks.
    task automatic send_frame(input int n_clocks);
        int unsigned style;
        logic [2:0]  fixed;
        style = $urandom_range(0, 5);
        fixed = 3'($urandom_range(0, 7));
        send_word(OP_DRDY, 3'($urandom_range(0, 7)), next_time());
        for (int i = 0; i < n_clocks; i++)
            send_word(OP_BCLK, frame_levels(style, fixed, i), next_time());
    endtask

    task automatic send_arm_trigger();
        send_word(OP_ARM, 3'($urandom_range(0, 7)), next_time());
        send_word(OP_TRIGGER, 3'($urandom_range(0, 7)), next_time());
    endtask

    // Random part of one setting. Most of it is well-formed acquisitions with random
    // frame contents; the rest is frames cut short or overrun, triggers in the middle
    // of a frame, and loose words of any kind.
    task automatic run_random(input int unsigned quota, input bit need_results);
        int unsigned first_word;
        int unsigned pick;
        first_word = words_sent;
        while ((words_sent - first_word) < quota
               || (need_results && results_seen < MIN_RESULTS)) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 1) != 0)
                        send_arm_trigger();
                    send_frame(FULL_FRAME_CLOCKS);
                end
            end else if (pick < 85) begin
                case ($urandom_range(0, 3))
                    0: begin
                        // A new data-ready edge arrives before the frame is complete.
                        send_frame($urandom_range(1, FULL_FRAME_CLOCKS - 1));
                        send_frame(FULL_FRAME_CLOCKS);
                    end
                    1: begin
                        // Bit clocks run on past the frame, up to saturating the count.
                        send_frame($urandom_range(FULL_FRAME_CLOCKS + 1, 80));
                    end
                    2: begin
                        // Trigger in the middle of a frame: ignored when already
                        // triggered, otherwise the open frame must never be emitted.
                        send_frame($urandom_range(1, FRAME_BITS));
                        send_word(OP_TRIGGER, 3'($urandom_range(0, 7)), next_time());
                        repeat ($urandom_range(1, FULL_FRAME_CLOCKS))
                            send_word(OP_BCLK, 3'($urandom_range(0, 7)), next_time());
                    end
                    default: begin
                        // Armed but not yet triggered: bits are counted, nothing emerges.
                        send_word(OP_ARM, 3'($urandom_range(0, 7)), next_time());
                        repeat ($urandom_range(1, FULL_FRAME_CLOCKS + 4))
                            send_word(OP_BCLK, 3'($urandom_range(0, 7)), next_time());
                        send_word(OP_TRIGGER, 3'($urandom_range(0, 7)), next_time());
                        repeat ($urandom_range(1, FULL_FRAME_CLOCKS))
                            send_word(OP_BCLK, 3'($urandom_range(0, 7)), next_time());
                        send_frame(FULL_FRAME_CLOCKS);
                    end
                endcase
            end else begin
                repeat ($urandom_range(1, 6))
                    send_word(op_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                              $urandom);
            end
        end
    endtask

    // Drops valid and waits until every predicted result has been taken, with a margin
    // either side for words still in flight and for the block to settle.
    task automatic wait_for_quiet();
        s_valid <= 1'b0;
        burst_left = 0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (n_expected != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the edge where
    // the access phase meets pready. The bus then goes idle before anything else.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [15:0] acq_settings [7];
        // Settings run through: one sample per acquisition, the largest count (the
        // following setting then falls below the samples already taken), zero, a
        // small random count, two, and back to one sample per acquisition.
        acq_settings    = '{16'd1, 16'hFFFF, 16'd3, 16'd0, 16'd4, 16'd2, 16'd1};
        acq_settings[4] = 16'($urandom_range(2, 6));
        t_us            = $urandom;

        aresetn       <= 1'b0;
        ask_long_hold <= 1'b0;
        s_valid       <= 1'b0;
        s_op          <= OP_ARM;
        s_line0       <= 1'b0;
        s_line1       <= 1'b0;
        s_line2       <= 1'b0;
        s_now_us      <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, with the sample count still at its reset value.
        // Bit clock, trigger and data-ready before arming are all ignored.
        send_word(OP_BCLK, 3'b111, 32'h0000_0000);
        send_word(OP_TRIGGER, 3'b000, 32'hFFFF_FFFF);
        send_word(OP_DRDY, 3'b111, 32'h8000_0000);
        // A second arm while armed changes nothing.
        send_word(OP_ARM, 3'b000, 32'h0000_0001);
        send_word(OP_ARM, 3'b101, 32'h7FFF_FFFF);
        // Armed but untriggered: the bit clocks are counted, nothing emerges,
        // and a data-ready edge is still ignored.
        send_word(OP_BCLK, 3'b111, 32'h0000_0002);
        send_word(OP_BCLK, 3'b010, 32'h0000_0003);
        send_word(OP_DRDY, 3'b000, 32'h0000_0004);
        send_word(OP_BCLK, 3'b000, 32'h0000_0005);
        // The trigger latches a start time close to the top of the range; the second
        // one is ignored. The frame already under way must never come out.
        send_word(OP_TRIGGER, 3'b111, 32'hFFFF_FFF0);
        send_word(OP_TRIGGER, 3'b000, 32'h0000_0000);
        send_word(OP_BCLK, 3'b111, 32'hFFFF_FFFF);
        send_word(OP_BCLK, 3'b000, 32'h0000_0000);
        wait_for_quiet();
        // A write to the address past the only register must leave everything alone.
        apb_write(UNUSED_REG_ADDR, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 7; ph++) begin
            apb_write(SAMPLE_COUNT_ADDR, {16'd0, acq_settings[ph]});
            // The largest count keeps the acquisition running, which gives the long
            // hold-off a steady supply of results to back up.
            if (ph == 1)
                ask_long_hold <= 1'b1;
            run_random(PHASE_WORDS, ph == 6);
            wait_for_quiet();
        end

        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* triggered_serial_adc_capture.f */
design/tsac_pkg.sv
design/tsac_core.sv
design/tsac_out_buf.sv
design/triggered_serial_adc_capture.sv
verif/capture_checker.sv
verif/testbench.sv
